[sv/fohs_pkg.sv]
// ============================================================================
// fohs_pkg: shared types, constants and microcode for the oscillator step unit
// ----------------------------------------------------------------------------
// Fixed-point formats, channel payloads, the control word of the sequencer
// and the read-only program that drives the datapath.
// ============================================================================
package fohs_pkg;

   // Number formats: signed Q8.24 state words.
   localparam int WORD_WIDTH      = 32;
   localparam int FRAC_BITS       = 24;
   localparam int FIELD_WIDTH     = 32;
   localparam int CFG_WIDTH       = 31;
   localparam int CFG_INDEX_WIDTH = 2;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [CFG_WIDTH-1:0]         cfg_value_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   // Configuration register indexes and reset values.
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STIFFNESS = 2'd0;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRICTION  = 2'd1;
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_STEP      = 2'd2;

   localparam cfg_value_type STIFFNESS_RESET = 31'd1006632960;
   localparam cfg_value_type FRICTION_RESET  = 31'd16458449;
   localparam cfg_value_type STEP_RESET      = 31'd83886;

   // Channel payloads.
   typedef struct packed {
      logic                          cmd;
      logic signed [FIELD_WIDTH-1:0] load_position;
      logic signed [FIELD_WIDTH-1:0] load_velocity;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] position;
      logic signed [FIELD_WIDTH-1:0] velocity;
      logic                          saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [CFG_INDEX_WIDTH-1:0] index;
      cfg_value_type              data;
   } csr_payload_type;

   // Command codes.
   localparam logic CMD_STEP = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   // Operand sources of the datapath.
   typedef enum logic [3:0] {
      SRC_Y, SRC_Z, SRC_H, SRC_K, SRC_S, SRC_QI, SRC_YP, SRC_ZP, SRC_QN, SRC_T
   } src_type;

   // Destinations of the adder.
   typedef enum logic [2:0] {
      DST_QI, DST_YP, DST_ZP, DST_QN, DST_T, DST_Y, DST_Z
   } dst_type;

   typedef enum logic [1:0] {
      ALU_NOP, ALU_ADD, ALU_FRIC, ALU_LOAD
   } alu_op_type;

   // Scaling of the product: by 2^FRAC_BITS or by 2^(FRAC_BITS+1).
   typedef enum logic [1:0] {
      SCALE_NOP, SCALE_FULL, SCALE_HALF
   } scale_type;

   typedef enum logic [1:0] {
      SEQ_NEXT, SEQ_JUMP, SEQ_JUMP_LOAD, SEQ_END
   } seq_type;

   localparam int PC_WIDTH = 4;
   typedef logic [PC_WIDTH-1:0] pc_type;

   localparam pc_type STEP_ENTRY = 4'd0;
   localparam pc_type END_ADDR   = 4'd12;
   localparam pc_type LOAD_ADDR  = 4'd13;

   typedef struct packed {
      seq_type    seq;
      pc_type     target;
      logic       mul_en;
      src_type    mul_a;
      src_type    mul_b;
      logic       mul_neg;
      scale_type  scale;
      alu_op_type alu_op;
      src_type    alu_a;
      src_type    alu_b;
      dst_type    alu_dst;
   } ctrl_word_type;

   // Control word together with its execute strobe, from sequencer to datapath.
   typedef struct packed {
      logic          exec;
      ctrl_word_type word;
   } seq_ctrl_type;

   localparam ctrl_word_type CW_IDLE = '{
      seq: SEQ_NEXT, target: STEP_ENTRY, mul_en: 1'b0, mul_a: SRC_Y, mul_b: SRC_Y,
      mul_neg: 1'b0, scale: SCALE_NOP, alu_op: ALU_NOP, alu_a: SRC_Y, alu_b: SRC_Y,
      alu_dst: DST_T};

   // Microcode program. The multiplier, the scaler and the adder each take one
   // field group of a word, so the three stages overlap on different operands.
   function automatic ctrl_word_type ucode(pc_type pc);
      ctrl_word_type w;
      w = CW_IDLE;
      case (pc)
         4'd0: begin
            // qi, part 1: -k*y; dispatch on the command.
            w.mul_en = 1'b1; w.mul_a = SRC_K; w.mul_b = SRC_Y; w.mul_neg = 1'b1;
            w.seq = SEQ_JUMP_LOAD; w.target = LOAD_ADDR;
         end
         4'd1: begin
            w.scale = SCALE_FULL;
            w.mul_en = 1'b1; w.mul_a = SRC_H; w.mul_b = SRC_Z;
         end
         4'd2: begin
            w.alu_op = ALU_FRIC; w.alu_a = SRC_S; w.alu_b = SRC_Z; w.alu_dst = DST_QI;
            w.scale = SCALE_FULL;
         end
         4'd3: begin
            w.alu_op = ALU_ADD; w.alu_a = SRC_Y; w.alu_b = SRC_S; w.alu_dst = DST_YP;
            w.mul_en = 1'b1; w.mul_a = SRC_H; w.mul_b = SRC_QI;
         end
         4'd4: begin
            w.scale = SCALE_FULL;
         end
         4'd5: begin
            w.alu_op = ALU_ADD; w.alu_a = SRC_Z; w.alu_b = SRC_S; w.alu_dst = DST_ZP;
            w.mul_en = 1'b1; w.mul_a = SRC_K; w.mul_b = SRC_YP; w.mul_neg = 1'b1;
         end
         4'd6: begin
            w.scale = SCALE_FULL;
            w.alu_op = ALU_ADD; w.alu_a = SRC_Z; w.alu_b = SRC_ZP; w.alu_dst = DST_T;
         end
         4'd7: begin
            w.alu_op = ALU_FRIC; w.alu_a = SRC_S; w.alu_b = SRC_ZP; w.alu_dst = DST_QN;
            w.mul_en = 1'b1; w.mul_a = SRC_H; w.mul_b = SRC_T;
         end
         4'd8: begin
            w.scale = SCALE_HALF;
            w.alu_op = ALU_ADD; w.alu_a = SRC_QI; w.alu_b = SRC_QN; w.alu_dst = DST_T;
         end
         4'd9: begin
            w.alu_op = ALU_ADD; w.alu_a = SRC_Y; w.alu_b = SRC_S; w.alu_dst = DST_Y;
            w.mul_en = 1'b1; w.mul_a = SRC_H; w.mul_b = SRC_T;
         end
         4'd10: begin
            w.scale = SCALE_HALF;
         end
         4'd11: begin
            w.alu_op = ALU_ADD; w.alu_a = SRC_Z; w.alu_b = SRC_S; w.alu_dst = DST_Z;
         end
         4'd12: begin
            w.seq = SEQ_END;
         end
         4'd13: begin
            w.alu_op = ALU_LOAD;
            w.seq = SEQ_JUMP; w.target = END_ADDR;
         end
         default: begin
            w.seq = SEQ_END;
         end
      endcase
      return w;
   endfunction

endpackage

[sv/fohs_stream_if.sv]
// ============================================================================
// fohs_stream_if: valid/ready channel
// ----------------------------------------------------------------------------
// One transaction moves when valid and ready are both high at a rising edge.
// ============================================================================
interface fohs_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[sv/friction_oscillator_heun_step_unit.sv]
// ============================================================================
// friction_oscillator_heun_step_unit: Heun step of a friction oscillator
// ----------------------------------------------------------------------------
// Top level: channel handshakes, configuration registers, result register.
// ============================================================================
// The unit holds the position and velocity of a mass-spring oscillator with
// Coulomb friction in signed Q8.24 and returns one result per request
// transaction. A step command advances the state by one Heun
// predictor-corrector step; a load command replaces the state and echoes it.
// One item is in work at a time; the microcode program runs the six scaled
// products of a step and their sums through a single shared multiplier,
// scaler and adder. The result register lets a new request be taken while
// the previous result still waits. Every clamp to the word range sets the
// saturated flag. Configuration writes are taken in every cycle and must be
// made only while no transaction is in work.
module friction_oscillator_heun_step_unit (
   input  logic         clock,
   input  logic         reset,
   fohs_stream_if.sink   req_chan,
   fohs_stream_if.source rsp_chan,
   fohs_stream_if.sink   csr_chan
);
   import fohs_pkg::*;

   cfg_value_type stiffness_ff, friction_ff, step_ff;
   logic          rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;

   logic         req_accept, csr_accept, out_free, busy, done;
   seq_ctrl_type ctrl;
   word_type     position, velocity;
   logic         saturated;
   req_payload_type req_payload;
   csr_payload_type csr_payload;

   assign req_payload = req_chan.payload;
   assign csr_payload = csr_chan.payload;

   // Handshakes.
   assign req_chan.ready = !busy;
   assign csr_chan.ready = 1'b1;
   assign req_accept     = req_chan.valid && !busy;
   assign csr_accept     = csr_chan.valid;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         stiffness_ff <= STIFFNESS_RESET;
         friction_ff  <= FRICTION_RESET;
         step_ff      <= STEP_RESET;
      end else if (csr_accept) begin
         case (csr_payload.index)
            CFG_STIFFNESS: stiffness_ff <= csr_payload.data;
            CFG_FRICTION:  friction_ff  <= csr_payload.data;
            CFG_STEP:      step_ff      <= csr_payload.data;
            default: begin
            end
         endcase
      end
   end

   fohs_sequencer u_sequencer (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept),
      .start_cmd (req_payload.cmd),
      .out_free  (out_free),
      .ctrl      (ctrl),
      .busy      (busy),
      .done      (done)
   );

   fohs_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .start          (req_accept),
      .start_position (word_type'(req_payload.load_position)),
      .start_velocity (word_type'(req_payload.load_velocity)),
      .ctrl           (ctrl),
      .stiffness      (word_type'({1'b0, stiffness_ff})),
      .friction       (word_type'({1'b0, friction_ff})),
      .step           (word_type'({1'b0, step_ff})),
      .position       (position),
      .velocity       (velocity),
      .saturated      (saturated)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_payload_ff.position  <= position[FIELD_WIDTH-1:0];
         rsp_payload_ff.velocity  <= velocity[FIELD_WIDTH-1:0];
         rsp_payload_ff.saturated <= saturated;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule

[sv/fohs_sequencer.sv]
// ============================================================================
// fohs_sequencer: step counter and microcode fetch
// ----------------------------------------------------------------------------
// Walks the program from the entry word on each accepted transaction, takes
// the command branch, and holds on the end word until the result register
// is free.
// ============================================================================
module fohs_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  start_cmd,
   input  logic                  out_free,
   output fohs_pkg::seq_ctrl_type ctrl,
   output logic                  busy,
   output logic                  done
);
   import fohs_pkg::*;

   logic          busy_ff, busy_in;
   pc_type        pc_ff, pc_in;
   logic          load_ff, load_in;
   ctrl_word_type word;

   // Fetch the current control word.
   always_comb begin
      word       = ucode(pc_ff);
      ctrl.exec  = busy_ff;
      ctrl.word  = word;
      busy       = busy_ff;
      done       = busy_ff && (word.seq == SEQ_END) && out_free;
   end

   // Next step and branch selection.
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      load_in = load_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            pc_in   = STEP_ENTRY;
            load_in = (start_cmd == CMD_LOAD);
         end
      end else begin
         case (word.seq)
            SEQ_NEXT:      pc_in = pc_ff + PC_WIDTH'(1);
            SEQ_JUMP:      pc_in = word.target;
            SEQ_JUMP_LOAD: pc_in = load_ff ? word.target : pc_ff + PC_WIDTH'(1);
            SEQ_END: begin
               if (out_free) begin
                  busy_in = 1'b0;
               end
            end
            default:       pc_in = pc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= STEP_ENTRY;
         load_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         load_ff <= load_in;
      end
   end

endmodule

[sv/fohs_datapath.sv]
// ============================================================================
// fohs_datapath: state registers, shared multiplier, scaler and adder
// ----------------------------------------------------------------------------
// Three stages driven by one control word: a magnitude multiplier, a
// round-and-clamp scaler, and a saturating adder with the friction term.
// ============================================================================
module fohs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fohs_pkg::word_type     start_position,
   input  fohs_pkg::word_type     start_velocity,
   input  fohs_pkg::seq_ctrl_type ctrl,
   input  fohs_pkg::word_type     stiffness,
   input  fohs_pkg::word_type     friction,
   input  fohs_pkg::word_type     step,
   output fohs_pkg::word_type     position,
   output fohs_pkg::word_type     velocity,
   output logic                   saturated
);
   import fohs_pkg::*;

   localparam int PROD_WIDTH = 2 * WORD_WIDTH;
   localparam int EXT_WIDTH  = PROD_WIDTH + 1;
   localparam logic [EXT_WIDTH-1:0] ROUND_FULL = EXT_WIDTH'(1) << (FRAC_BITS - 1);
   localparam logic [EXT_WIDTH-1:0] ROUND_HALF = EXT_WIDTH'(1) << FRAC_BITS;
   localparam logic [EXT_WIDTH-1:0] LIMIT_POS  =
      {{(EXT_WIDTH-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};

   // State and scratch registers.
   word_type y_ff, z_ff, qi_ff, yp_ff, zp_ff, qn_ff, t_ff, s_ff;
   word_type ld_pos_ff, ld_vel_ff;
   logic [PROD_WIDTH-1:0] p_ff, p_in;
   logic                  p_neg_ff, p_neg_in;
   logic                  p_inv_ff, p_inv_in;
   logic                  sat_ff;

   ctrl_word_type w;
   word_type mul_a_val, mul_b_val, alu_a_val, alu_b_val;
   logic [WORD_WIDTH-1:0] mag_a, mag_b;

   logic [EXT_WIDTH-1:0] lo2, scaled, limit;
   logic [WORD_WIDTH-1:0] clamped_mag;
   logic                 scale_over;
   logic                 res_neg;
   word_type             s_in;

   word_type                addend;
   logic signed [WORD_WIDTH:0] sum;
   logic                    alu_over;
   word_type                alu_res;

   function automatic word_type pick(src_type s);
      word_type v;
      case (s)
         SRC_Y:   v = y_ff;
         SRC_Z:   v = z_ff;
         SRC_H:   v = step;
         SRC_K:   v = stiffness;
         SRC_S:   v = s_ff;
         SRC_QI:  v = qi_ff;
         SRC_YP:  v = yp_ff;
         SRC_ZP:  v = zp_ff;
         SRC_QN:  v = qn_ff;
         SRC_T:   v = t_ff;
         default: v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] mag(word_type v);
      logic [WORD_WIDTH-1:0] u;
      u = v;
      return u[WORD_WIDTH-1] ? (~u + WORD_WIDTH'(1)) : u;
   endfunction

   // Operand selection.
   always_comb begin
      w         = ctrl.word;
      mul_a_val = pick(w.mul_a);
      mul_b_val = pick(w.mul_b);
      alu_a_val = pick(w.alu_a);
      alu_b_val = pick(w.alu_b);
   end

   // Multiplier stage: product of magnitudes, the sign of the product and
   // whether the scaled product is to be negated afterwards.
   always_comb begin
      mag_a    = mag(mul_a_val);
      mag_b    = mag(mul_b_val);
      p_in     = PROD_WIDTH'(mag_a) * PROD_WIDTH'(mag_b);
      p_neg_in = mul_a_val[WORD_WIDTH-1] ^ mul_b_val[WORD_WIDTH-1];
      p_inv_in = w.mul_neg;
   end

   // Scaler stage: round half away from zero, shift down, clamp, apply sign.
   // A negated product is clamped first and then negated with saturation,
   // so its magnitude never exceeds the largest positive word.
   always_comb begin
      if (w.scale == SCALE_HALF) begin
         lo2    = {1'b0, p_ff} + ROUND_HALF;
         scaled = lo2 >> (FRAC_BITS + 1);
      end else begin
         lo2    = {1'b0, p_ff} + ROUND_FULL;
         scaled = lo2 >> FRAC_BITS;
      end
      limit       = LIMIT_POS + EXT_WIDTH'(p_neg_ff && !p_inv_ff);
      scale_over  = scaled > limit;
      res_neg     = p_neg_ff ^ p_inv_ff;
      clamped_mag = scale_over ? limit[WORD_WIDTH-1:0] : scaled[WORD_WIDTH-1:0];
      s_in = res_neg ? word_type'(~clamped_mag + WORD_WIDTH'(1)) : word_type'(clamped_mag);
   end

   // Adder stage; the friction op adds -f, +f or nothing by the sign of B.
   always_comb begin
      if (w.alu_op == ALU_FRIC) begin
         if (alu_b_val[WORD_WIDTH-1]) begin
            addend = friction;
         end else if (alu_b_val != '0) begin
            addend = -friction;
         end else begin
            addend = '0;
         end
      end else begin
         addend = alu_b_val;
      end
      sum      = {alu_a_val[WORD_WIDTH-1], alu_a_val} + {addend[WORD_WIDTH-1], addend};
      alu_over = sum[WORD_WIDTH] ^ sum[WORD_WIDTH-1];
      if (alu_over) begin
         alu_res = sum[WORD_WIDTH] ? WORD_MIN : WORD_MAX;
      end else begin
         alu_res = sum[WORD_WIDTH-1:0];
      end
   end

   // Control-side registers: state and the saturation flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         y_ff   <= '0;
         z_ff   <= '0;
         sat_ff <= 1'b0;
      end else if (start) begin
         sat_ff <= 1'b0;
      end else if (ctrl.exec) begin
         if ((w.scale == SCALE_FULL || w.scale == SCALE_HALF) && scale_over) begin
            sat_ff <= 1'b1;
         end
         if ((w.alu_op == ALU_ADD || w.alu_op == ALU_FRIC) && alu_over) begin
            sat_ff <= 1'b1;
         end
         case (w.alu_op)
            ALU_LOAD: begin
               y_ff <= ld_pos_ff;
               z_ff <= ld_vel_ff;
            end
            ALU_ADD, ALU_FRIC: begin
               if (w.alu_dst == DST_Y) begin
                  y_ff <= alu_res;
               end
               if (w.alu_dst == DST_Z) begin
                  z_ff <= alu_res;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Payload registers: loaded values, product, scaled value and temporaries.
   always_ff @(posedge clock) begin
      if (start) begin
         ld_pos_ff <= start_position;
         ld_vel_ff <= start_velocity;
      end
      if (ctrl.exec) begin
         if (w.mul_en) begin
            p_ff     <= p_in;
            p_neg_ff <= p_neg_in;
            p_inv_ff <= p_inv_in;
         end
         if (w.scale == SCALE_FULL || w.scale == SCALE_HALF) begin
            s_ff <= s_in;
         end
         if (w.alu_op == ALU_ADD || w.alu_op == ALU_FRIC) begin
            case (w.alu_dst)
               DST_QI:  qi_ff <= alu_res;
               DST_YP:  yp_ff <= alu_res;
               DST_ZP:  zp_ff <= alu_res;
               DST_QN:  qn_ff <= alu_res;
               DST_T:   t_ff  <= alu_res;
               default: begin
               end
            endcase
         end
      end
   end

   assign position  = y_ff;
   assign velocity  = z_ff;
   assign saturated = sat_ff;

endmodule

[dv/friction_oscillator_heun_step_unit_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// friction_oscillator_heun_step_unit_tb: self-checking bench for the Heun step
// ----------------------------------------------------------------------------
// Drives load and step commands through the request channel and tracks the
// oscillator state in a bit-true Q8.24 predictor with saturation. Each result
// is checked field by field against the oldest expectation. A short table of
// directed rows comes first. Several register settings follow, extremes
// among them, each with random load-then-step sequences. The sender runs in
// bursts and the receiver stalls in changing patterns.
// ============================================================================
module friction_oscillator_heun_step_unit_tb;
   import fohs_pkg::*;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 20;
   localparam int DRAIN_CYCLES  = 40;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 132;
   localparam int DIRECTED_ROWS = 20;
   localparam int PRINT_LIMIT   = 100;

   // Index with no register behind it; writes to it must change nothing.
   localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SPARE = 2'd3;
   localparam cfg_value_type CFG_MAX = {CFG_WIDTH{1'b1}};

   localparam longint W_MAX = longint'(WORD_MAX);
   localparam longint W_MIN = longint'(WORD_MIN);

   typedef enum logic [1:0] {SINK_OPEN, SINK_COIN, SINK_RHYTHM, SINK_HOLD} sink_mode_type;

   typedef struct {
      logic        cmd;
      logic [31:0] position;
      logic [31:0] velocity;
      bit          known;
      logic [31:0] want_position;
      logic [31:0] want_velocity;
      logic        want_saturated;
   } directed_row_type;

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;

   fohs_stream_if #(.payload_type(req_payload_type)) req_chan ();
   fohs_stream_if #(.payload_type(rsp_payload_type)) rsp_chan ();
   fohs_stream_if #(.payload_type(csr_payload_type)) csr_chan ();

   assign rsp_chan.ready = sink_ready;

   friction_oscillator_heun_step_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Predictor state: registers and oscillator state, all within word range.
   longint k_ratio;
   longint fric_accel;
   longint h_step;
   longint osc_position;
   longint osc_velocity;
   bit     clamp_hit;

   rsp_payload_type expected_responses[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;

   sink_mode_type sink_mode = SINK_OPEN;
   int sink_left = 0;
   int hold_left = 0;

   // Directed rows: register reset values; echoes and all-zero steps are known.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{CMD_LOAD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'h8000_0000, 32'h8000_0000, 1'b0},
      '{CMD_STEP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{CMD_STEP, 32'h1234_5678, 32'h8765_4321, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{CMD_LOAD, 32'h0100_0000, 32'h0000_0000, 1'b1, 32'h0100_0000, 32'h0000_0000, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'h0000_0000, 32'h0010_0000, 1'b1, 32'h0000_0000, 32'h0010_0000, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'h0000_0000, 32'hFFF0_0000, 1'b1, 32'h0000_0000, 32'hFFF0_0000, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_LOAD, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0},
      '{CMD_STEP, 32'h0000_0000, 32'h0000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
      '{CMD_STEP, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0, 32'h0, 1'b0}
   };

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Saturating word arithmetic; any clamp raises the saturation flag.
   function automatic longint clamp_word(longint v);
      if (v > W_MAX) begin
         clamp_hit = 1'b1;
         return W_MAX;
      end
      if (v < W_MIN) begin
         clamp_hit = 1'b1;
         return W_MIN;
      end
      return v;
   endfunction

   function automatic longint sat_add(longint a, longint b);
      return clamp_word(a + b);
   endfunction

   function automatic longint sat_neg(longint a);
      return clamp_word(-a);
   endfunction

   // Exact product scaled by 2^shift, rounded half away from zero, clamped.
   function automatic longint scaled_product(longint a, longint b, int shift);
      bit neg;
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned prod;
      longint unsigned limit;
      neg = (a < 0) != (b < 0);
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = ma * mb;
      prod = (prod + (64'd1 << (shift - 1))) >> shift;
      limit = neg ? longint'(W_MAX) + 1 : longint'(W_MAX);
      if (prod > limit) begin
         clamp_hit = 1'b1;
         return neg ? W_MIN : W_MAX;
      end
      return neg ? -longint'(prod) : longint'(prod);
   endfunction

   // Spring plus Coulomb friction acceleration; no friction at zero velocity.
   function automatic longint spring_friction_accel(longint y, longint z);
      longint acc;
      acc = sat_neg(scaled_product(k_ratio, y, FRAC_BITS));
      if (z > 0)
         acc = sat_add(acc, sat_neg(fric_accel));
      else if (z < 0)
         acc = sat_add(acc, fric_accel);
      return acc;
   endfunction

   // Advances the predicted state for one request and returns its result.
   function automatic rsp_payload_type predict_response(req_payload_type item);
      rsp_payload_type r;
      longint qi;
      longint yp;
      longint zp;
      longint qn;
      longint ny;
      longint nz;
      clamp_hit = 1'b0;
      if (item.cmd == CMD_LOAD) begin
         osc_position = clamp_word(longint'(item.load_position));
         osc_velocity = clamp_word(longint'(item.load_velocity));
      end else begin
         qi = spring_friction_accel(osc_position, osc_velocity);
         yp = sat_add(osc_position, scaled_product(h_step, osc_velocity, FRAC_BITS));
         zp = sat_add(osc_velocity, scaled_product(h_step, qi, FRAC_BITS));
         qn = spring_friction_accel(yp, zp);
         ny = sat_add(osc_position,
                      scaled_product(h_step, sat_add(osc_velocity, zp), FRAC_BITS + 1));
         nz = sat_add(osc_velocity,
                      scaled_product(h_step, sat_add(qi, qn), FRAC_BITS + 1));
         osc_position = ny;
         osc_velocity = nz;
      end
      r.position  = osc_position[31:0];
      r.velocity  = osc_velocity[31:0];
      r.saturated = clamp_hit;
      return r;
   endfunction

   function automatic void apply_register(logic [CFG_INDEX_WIDTH-1:0] idx, cfg_value_type value);
      case (idx)
         CFG_STIFFNESS: k_ratio = clamp_word(longint'(value));
         CFG_FRICTION:  fric_accel = clamp_word(longint'(value));
         CFG_STEP:      h_step = clamp_word(longint'(value));
         default: ;
      endcase
   endfunction

   // Register value for a random phase: extremes, reset value, full range or
   // a physically sensible range.
   function automatic cfg_value_type draw_register(logic [CFG_INDEX_WIDTH-1:0] idx);
      logic [31:0] raw;
      cfg_value_type bound;
      cfg_value_type home;
      cfg_value_type value;
      case (idx)
         CFG_STIFFNESS: begin
            bound = 31'd1677721600;
            home = STIFFNESS_RESET;
         end
         CFG_FRICTION: begin
            bound = 31'd83886080;
            home = FRICTION_RESET;
         end
         default: begin
            bound = 31'd838861;
            home = STEP_RESET;
         end
      endcase
      case ($urandom_range(0, 5))
         0: value = '0;
         1: value = CFG_MAX;
         2: begin
            raw = $urandom;
            value = raw[CFG_WIDTH-1:0];
         end
         3: value = home;
         default: begin
            raw = $urandom_range(0, bound);
            value = raw[CFG_WIDTH-1:0];
         end
      endcase
      return value;
   endfunction

   // State word for a load: mostly modest magnitudes, some full range or zero.
   function automatic logic [31:0] random_state_word();
      logic [31:0] v;
      int unsigned span;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = '0;
         default: begin
            span = $urandom_range(4, 30);
            v = $urandom & ((32'd1 << span) - 32'd1);
            if ($urandom_range(0, 1) == 1)
               v = -v;
         end
      endcase
      return v;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
   endtask

   // Sends one request transaction; the sender may idle between bursts.
   task automatic issue_item(input req_payload_type item, input bit known,
                             input rsp_payload_type want);
      rsp_payload_type predicted;
      int gap;
      req_chan.valid <= 1'b1;
      req_chan.payload <= item;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_response(item);
      expected_responses.push_back(known ? want : predicted);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Leaves csr valid high so back-to-back writes need no second assignment.
   task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                 input cfg_value_type value);
      csr_payload_type w;
      w.index = idx;
      w.data = value;
      csr_chan.valid <= 1'b1;
      csr_chan.payload <= w;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      apply_register(idx, value);
   endtask

   task automatic wait_until_idle();
      while (expected_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result receiver: picks a new stall pattern when the current one runs out.
   always @(posedge clock) begin : drive_result_ready
      logic [31:0] pick;
      if (sink_left <= 0) begin
         pick = $urandom_range(0, 3);
         sink_mode = sink_mode_type'(pick[1:0]);
         sink_left = $urandom_range(100, 400);
      end
      sink_left--;
      case (sink_mode)
         SINK_OPEN:   sink_ready <= 1'b1;
         SINK_COIN:   sink_ready <= ($urandom_range(0, 1) == 1);
         SINK_RHYTHM: sink_ready <= (sink_left % 4) != 0;
         default: begin
            if (hold_left > 0) begin
               hold_left--;
               sink_ready <= 1'b0;
            end else if ($urandom_range(0, 7) == 0) begin
               hold_left = $urandom_range(1, 20);
               sink_ready <= 1'b0;
            end else begin
               sink_ready <= 1'b1;
            end
         end
      endcase
   end

   // Result checker: each transaction against the oldest expectation.
   always @(posedge clock) begin : check_results
      rsp_payload_type want;
      if (!reset && rsp_chan.valid && sink_ready) begin
         if (expected_responses.size() == 0) begin
            report_mismatch("unexpected result", rsp_chan.payload.position, 32'h0);
         end else begin
            want = expected_responses.pop_front();
            if (rsp_chan.payload.position !== want.position)
               report_mismatch("position", rsp_chan.payload.position, want.position);
            if (rsp_chan.payload.velocity !== want.velocity)
               report_mismatch("velocity", rsp_chan.payload.velocity, want.velocity);
            if (rsp_chan.payload.saturated !== want.saturated)
               report_mismatch("saturated", {31'd0, rsp_chan.payload.saturated},
                               {31'd0, want.saturated});
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      req_payload_type item;
      rsp_payload_type want;
      cfg_value_type k;
      cfg_value_type f;
      cfg_value_type h;
      logic [31:0] spare;
      int issued;
      int steps;
      int n;

      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.payload <= '0;
      csr_chan.valid <= 1'b0;
      csr_chan.payload <= '0;
      apply_register(CFG_STIFFNESS, STIFFNESS_RESET);
      apply_register(CFG_FRICTION, FRICTION_RESET);
      apply_register(CFG_STEP, STEP_RESET);
      osc_position = 0;
      osc_velocity = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows at the reset register values.
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         item.cmd = directed_rows[r].cmd;
         item.load_position = directed_rows[r].position;
         item.load_velocity = directed_rows[r].velocity;
         want.position = directed_rows[r].want_position;
         want.velocity = directed_rows[r].want_velocity;
         want.saturated = directed_rows[r].want_saturated;
         issue_item(item, directed_rows[r].known, want);
      end
      req_chan.valid <= 1'b0;

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_until_idle();
         case (phase)
            0: begin
               k = CFG_MAX;
               f = CFG_MAX;
               h = CFG_MAX;
            end
            1: begin
               k = '0;
               f = '0;
               h = '0;
            end
            2: begin
               // Zero step with live spring and friction: state must hold.
               k = STIFFNESS_RESET;
               f = FRICTION_RESET;
               h = '0;
            end
            default: begin
               k = draw_register(CFG_STIFFNESS);
               f = draw_register(CFG_FRICTION);
               h = draw_register(CFG_STEP);
            end
         endcase
         spare = $urandom;
         write_register(CFG_STIFFNESS, k);
         write_register(CFG_FRICTION, f);
         write_register(CFG_STEP, h);
         write_register(CFG_SPARE, spare[CFG_WIDTH-1:0]);
         csr_chan.valid <= 1'b0;
         @(posedge clock);

         // Load a state, then run a trajectory of steps from it.
         issued = 0;
         while (issued < PHASE_ITEMS) begin
            item.cmd = CMD_LOAD;
            item.load_position = random_state_word();
            item.load_velocity = random_state_word();
            issue_item(item, 1'b0, '0);
            issued++;
            steps = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2)
                                                : $urandom_range(4, 40);
            for (n = 0; n < steps && issued < PHASE_ITEMS; n++) begin
               item.cmd = CMD_STEP;
               item.load_position = $urandom;
               item.load_velocity = $urandom;
               issue_item(item, 1'b0, '0);
               issued++;
            end
         end
         req_chan.valid <= 1'b0;
      end

      while (expected_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

[files.f]
sv/fohs_pkg.sv
sv/fohs_stream_if.sv
sv/fohs_sequencer.sv
sv/fohs_datapath.sv
sv/friction_oscillator_heun_step_unit.sv
dv/friction_oscillator_heun_step_unit_tb.sv
